// ----- hdl/fpll_pkg.sv -----
// Package for the frame pacing lock loop.
// Holds the request types, the sequencer states, control structs and constants.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package fpll_pkg;

    localparam int TIME_BITS  = 48;
    localparam int SLEEP_W    = 24;
    localparam int EXP_W      = 32;
    localparam int MS_W       = 10;
    localparam int DELAY_W    = 25;
    localparam int X_W        = 18;
    localparam int QUOT_W     = EXP_W + 15;
    localparam int ALU_W      = TIME_BITS + 1;
    localparam int CNT_W      = 6;

    localparam logic [SLEEP_W-1:0] MAX_SLEEP_US    = 24'd16777215;
    localparam logic [SLEEP_W-1:0] SLEEP_FLOOR     = 24'd500;
    localparam logic [X_W-1:0]     X_MIN           = 18'd63308;
    localparam logic [X_W-1:0]     X_MAX           = 18'd131072;
    localparam logic [X_W-1:0]     X_LOCK_LO       = 18'd64881;
    localparam logic [X_W-1:0]     X_LOCK_HI       = 18'd66191;
    localparam logic [X_W-1:0]     X_HALF          = 18'd32768;
    localparam logic [16:0]        Q_LIMIT         = 17'd98304;
    localparam logic [TIME_BITS-1:0] FLL_MIN_ELAPSED = 48'd40000;
    localparam logic [2:0]         LOCK_FULL       = 3'sd3;
    localparam logic [2:0]         LOCK_ARMED      = 3'b111;
    localparam logic [CNT_W-1:0]   DIV_LAST        = CNT_W'(QUOT_W - 1);
    localparam logic [CNT_W-1:0]   MUL_LAST        = CNT_W'(X_W - 1);

    typedef struct packed {
        logic [TIME_BITS-1:0] now_us;
        logic [MS_W-1:0]      frame_ms;
    } t_in_req;

    typedef struct packed {
        logic [DELAY_W-1:0] delay_us;
        logic               phase_mode;
    } t_out_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ELAP,
        S_PH1,
        S_PH2,
        S_WCHK,
        S_WADJ,
        S_FCHK,
        S_DIV,
        S_XCLP,
        S_MUL,
        S_FUPD,
        S_FIN
    } t_state;

    typedef struct packed {
        t_state st;
        logic   in_acc;
        logic   out_load;
    } t_ctl;

    typedef struct packed {
        logic phase_go;
        logic freq_go;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ----- hdl/fpll_addsub.sv -----
// Shared add/subtract unit of the frame pacing lock loop.
// Serves the restoring divider and the shift-add multiplier; uses fpll_pkg.
`default_nettype none

module fpll_addsub (
    input  wire logic [fpll_pkg::ALU_W-1:0] i_a,
    input  wire logic [fpll_pkg::ALU_W-1:0] i_b,
    input  wire logic                       i_sub,
    output logic      [fpll_pkg::ALU_W-1:0] o_sum,
    output logic                            o_cout
);

    logic [fpll_pkg::ALU_W-1:0] b_op;
    logic [fpll_pkg::ALU_W:0]   full;

    always_comb begin
        b_op = i_sub ? ~i_b : i_b;
        full = {1'b0, i_a} + {1'b0, b_op} + {{fpll_pkg::ALU_W{1'b0}}, i_sub};
    end

    assign o_sum  = full[fpll_pkg::ALU_W-1:0];
    assign o_cout = full[fpll_pkg::ALU_W];

endmodule

`default_nettype wire

// ----- hdl/fpll_ctrl.sv -----
// Sequencer of the frame pacing lock loop.
// Steps one request through its phases and counts divide and multiply steps; uses fpll_pkg.
`default_nettype none

module fpll_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire fpll_pkg::t_sts   i_sts,
    output fpll_pkg::t_ctl        o_ctl
);

    fpll_pkg::t_state r_state, n_state;
    logic [fpll_pkg::CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpll_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        o_ctl.st       = r_state;
        o_ctl.in_acc   = 1'b0;
        o_ctl.out_load = 1'b0;
        case (r_state)
            fpll_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.in_acc = 1'b1;
                    n_state      = fpll_pkg::S_ELAP;
                end
            end
            fpll_pkg::S_ELAP: n_state = fpll_pkg::S_PH1;
            fpll_pkg::S_PH1: begin
                n_state = i_sts.phase_go ? fpll_pkg::S_PH2 : fpll_pkg::S_FCHK;
            end
            fpll_pkg::S_PH2:  n_state = fpll_pkg::S_WCHK;
            fpll_pkg::S_WCHK: n_state = fpll_pkg::S_WADJ;
            fpll_pkg::S_WADJ: n_state = fpll_pkg::S_FCHK;
            fpll_pkg::S_FCHK: begin
                n_cnt   = '0;
                n_state = i_sts.freq_go ? fpll_pkg::S_DIV : fpll_pkg::S_FIN;
            end
            fpll_pkg::S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == fpll_pkg::DIV_LAST) begin
                    n_state = fpll_pkg::S_XCLP;
                end
            end
            fpll_pkg::S_XCLP: begin
                n_cnt   = '0;
                n_state = fpll_pkg::S_MUL;
            end
            fpll_pkg::S_MUL: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == fpll_pkg::MUL_LAST) begin
                    n_state = fpll_pkg::S_FUPD;
                end
            end
            fpll_pkg::S_FUPD: n_state = fpll_pkg::S_FIN;
            fpll_pkg::S_FIN: begin
                if (i_sts.out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = fpll_pkg::S_IDLE;
                end
            end
            default: n_state = fpll_pkg::S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/frame_pacing_lock_loop.sv -----
// Top level of the frame pacing lock loop: loop state, datapath and output register.
// Uses fpll_pkg, fpll_addsub and fpll_ctrl.
//
// Usage: each input request is one frame tick with a microsecond timestamp and
// the target frame period in ms; each one yields exactly one output request
// with the delay to wait before the next frame and the phase-lock flag.
// Both channels use valid/ready. The block takes one request at a time:
// o_in_ready is high only while the sequencer is idle.
// Sequence: after a request is accepted the sequencer computes the elapsed
// time and checks the phase loop; when the phase correction runs it sets the
// delay and checks for a wrap. A frequency update adds a 47-step restoring
// divide and an 18-step shift-add multiply on the shared adder, with a clamp
// step between them and an update step after. The next request is taken in
// the cycle after the result is loaded, even if the receiver has not yet taken
// it; a stalled receiver holds the following result in its last sequencer
// step until the output register frees.
// Reset (synchronous, active low) clears the loop state: the first tick after
// reset sets the reference time and the sleep time from its frame period.
`default_nettype none

module frame_pacing_lock_loop (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire fpll_pkg::t_in_req i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output fpll_pkg::t_out_req     o_out_data
);

    localparam int TB = fpll_pkg::TIME_BITS;
    localparam int SW = fpll_pkg::SLEEP_W;
    localparam int EW = fpll_pkg::EXP_W;
    localparam int DW = fpll_pkg::DELAY_W;
    localparam int XW = fpll_pkg::X_W;
    localparam int QW = fpll_pkg::QUOT_W;
    localparam int AW = fpll_pkg::ALU_W;

    fpll_pkg::t_ctl ctl;
    fpll_pkg::t_sts sts;

    logic               r_started;
    logic [TB-1:0]      r_ref;
    logic [EW-1:0]      r_ex;
    logic [SW-1:0]      r_sl;
    logic signed [2:0]  r_lock;
    logic               r_out_valid;
    fpll_pkg::t_out_req r_out_data;

    logic [TB-1:0]      r_now;
    logic [19:0]        r_ms1000;
    logic [TB-1:0]      r_elapsed;
    logic [EW:0]        r_target;
    logic [SW+4:0]      r_sl20;
    logic               r_gt;
    logic [EW:0]        r_diff;
    logic               r_wrap;
    logic [DW-1:0]      r_delay;
    logic               r_phase;
    logic [TB-1:0]      r_rem;
    logic [QW-1:0]      r_dq;
    logic [XW-1:0]      r_x;
    logic [SW-1:0]      r_acc;
    logic [XW-1:0]      r_mq;

    logic [19:0]        in_ms1000;
    logic [SW-1:0]      init_sl;
    logic [AW-1:0]      alu_a;
    logic [AW-1:0]      alu_b;
    logic               alu_sub;
    logic [AW-1:0]      alu_sum;
    logic               alu_cout;
    logic [DW-1:0]      sl2;
    logic [SW+5:0]      sl40;
    logic [XW-1:0]      x_raw;
    logic [XW-1:0]      x_next;
    logic [SW+1:0]      sl_raw;
    logic [SW-1:0]      sl_next;
    logic               lock_hit;

    fpll_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    fpll_addsub u_alu (
        .i_a    (alu_a),
        .i_b    (alu_b),
        .i_sub  (alu_sub),
        .o_sum  (alu_sum),
        .o_cout (alu_cout)
    );

    always_comb begin
        in_ms1000 = 20'(i_in_data.frame_ms) * 20'd1000;
        if ({4'b0, in_ms1000} > fpll_pkg::MAX_SLEEP_US) begin
            init_sl = fpll_pkg::MAX_SLEEP_US;
        end else begin
            init_sl = SW'(in_ms1000);
        end

        if (ctl.st == fpll_pkg::S_DIV) begin
            alu_a   = {r_rem, r_dq[QW-1]};
            alu_b   = {1'b0, r_elapsed};
            alu_sub = 1'b1;
        end else begin
            alu_a   = {{(AW-SW){1'b0}}, r_acc};
            alu_b   = r_mq[0] ? {{(AW-SW){1'b0}}, r_sl} : '0;
            alu_sub = 1'b0;
        end

        sl2  = {r_sl, 1'b0};
        sl40 = {r_sl20, 1'b0};

        x_raw = fpll_pkg::X_HALF + {1'b0, r_dq[16:0]};
        if ((r_dq[QW-1:17] != '0) || (r_dq[16:0] > fpll_pkg::Q_LIMIT)) begin
            x_next = fpll_pkg::X_MAX;
        end else if (x_raw < fpll_pkg::X_MIN) begin
            x_next = fpll_pkg::X_MIN;
        end else begin
            x_next = x_raw;
        end

        sl_raw = {r_acc, r_mq[XW-1:XW-2]};
        if (sl_raw < {2'b0, fpll_pkg::SLEEP_FLOOR}) begin
            sl_next = fpll_pkg::SLEEP_FLOOR;
        end else if (sl_raw > {2'b0, fpll_pkg::MAX_SLEEP_US}) begin
            sl_next = fpll_pkg::MAX_SLEEP_US;
        end else begin
            sl_next = sl_raw[SW-1:0];
        end
        lock_hit = (r_x >= fpll_pkg::X_LOCK_LO) && (r_x <= fpll_pkg::X_LOCK_HI)
                   && (sl_next > {5'b0, r_ms1000[19:1]});

        sts.phase_go = (r_lock > 3'sd0) && (r_elapsed != '0);
        sts.freq_go  = (r_lock <= 3'sd0) && (r_elapsed > fpll_pkg::FLL_MIN_ELAPSED);
        sts.out_free = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started   <= 1'b0;
            r_ref       <= '0;
            r_ex        <= '0;
            r_sl        <= '0;
            r_lock      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (ctl.in_acc && !r_started) begin
                r_started <= 1'b1;
                r_ref     <= i_in_data.now_us;
                r_sl      <= init_sl;
            end
            if (ctl.st == fpll_pkg::S_PH2) begin
                if (r_gt || (r_diff > {8'b0, sl2})) begin
                    r_lock <= r_lock - 3'sd1;
                end else begin
                    r_lock <= fpll_pkg::LOCK_FULL;
                end
            end
            if ((ctl.st == fpll_pkg::S_WADJ) && r_wrap) begin
                r_ex  <= r_ex - {3'b0, r_sl20};
                r_ref <= r_ref + {{(TB-SW-5){1'b0}}, r_sl20};
            end
            if (ctl.st == fpll_pkg::S_FUPD) begin
                r_sl  <= sl_next;
                r_ref <= r_now;
                r_ex  <= '0;
                if (lock_hit) begin
                    r_lock <= (r_lock == 3'sd0) ? fpll_pkg::LOCK_ARMED
                                                : fpll_pkg::LOCK_FULL;
                end else begin
                    r_lock <= '0;
                end
            end
            if (ctl.out_load) begin
                r_ex        <= r_ex + {12'b0, r_ms1000};
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (ctl.st)
            fpll_pkg::S_IDLE: begin
                if (ctl.in_acc) begin
                    r_now    <= i_in_data.now_us;
                    r_ms1000 <= in_ms1000;
                end
            end
            fpll_pkg::S_ELAP: begin
                r_elapsed <= r_now - r_ref;
                r_target  <= {1'b0, r_ex} + {9'b0, r_sl};
                r_sl20    <= {1'b0, r_sl, 4'b0} + {3'b0, r_sl, 2'b0};
                r_delay   <= {1'b0, r_sl};
                r_phase   <= 1'b0;
            end
            fpll_pkg::S_PH1: begin
                r_gt   <= r_elapsed > {{(TB-EW-1){1'b0}}, r_target};
                r_diff <= r_target - r_elapsed[EW:0];
            end
            fpll_pkg::S_PH2: begin
                r_phase <= 1'b1;
                if (r_gt) begin
                    r_delay <= '0;
                end else if (r_diff > {8'b0, sl2}) begin
                    r_delay <= sl2;
                end else begin
                    r_delay <= r_diff[DW-1:0];
                end
            end
            fpll_pkg::S_WCHK: begin
                r_wrap <= (r_elapsed > {{(TB-SW-6){1'b0}}, sl40})
                          && (r_ex > {2'b0, sl40});
            end
            fpll_pkg::S_WADJ: begin
                if (r_wrap) begin
                    r_elapsed <= r_elapsed - {{(TB-SW-5){1'b0}}, r_sl20};
                end
            end
            fpll_pkg::S_FCHK: begin
                r_rem <= '0;
                r_dq  <= {r_ex, 15'b0};
            end
            fpll_pkg::S_DIV: begin
                r_rem <= alu_cout ? alu_sum[TB-1:0] : alu_a[TB-1:0];
                r_dq  <= {r_dq[QW-2:0], alu_cout};
            end
            fpll_pkg::S_XCLP: begin
                r_x   <= x_next;
                r_mq  <= x_next;
                r_acc <= '0;
            end
            fpll_pkg::S_MUL: begin
                r_acc <= alu_sum[SW:1];
                r_mq  <= {alu_sum[0], r_mq[XW-1:1]};
            end
            fpll_pkg::S_FUPD: begin
                r_delay <= {1'b0, sl_next};
                r_phase <= 1'b0;
            end
            fpll_pkg::S_FIN: begin
                if (ctl.out_load) begin
                    r_out_data.delay_us   <= r_delay;
                    r_out_data.phase_mode <= r_phase;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_ready  = (ctl.st == fpll_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire
